### rtl/pceo_pkg.sv
// ----------------------------------------------------------------------------
// pceo_pkg
// shared constants and types for the circle versus polygon edge overlap block
// ----------------------------------------------------------------------------
`default_nettype none

package pceo_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int RADIUS_BITS    = 15;
	localparam int QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} pceo_qstat_t;

endpackage

`default_nettype wire

### rtl/pceo_front.sv
// ----------------------------------------------------------------------------
// pceo_front
// accepts vertices, tracks the polygon and issues one edge job per edge, or one point job for a single vertex polygon
// ----------------------------------------------------------------------------
`default_nettype none

module pceo_front #(
	parameter int COORD_BITS = pceo_pkg::COORD_BITS_DEF,
	localparam int JOB_W = 6 * COORD_BITS + pceo_pkg::RADIUS_BITS + 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [COORD_BITS-1:0]     vertex_x,
	input  wire logic signed [COORD_BITS-1:0]     vertex_y,
	input  wire logic signed [COORD_BITS-1:0]     center_x,
	input  wire logic signed [COORD_BITS-1:0]     center_y,
	input  wire logic [pceo_pkg::RADIUS_BITS-1:0] radius,
	input  wire logic                             last_vertex,
	input  wire pceo_pkg::pceo_qstat_t            q_stat,
	output logic                                  push,
	output logic [JOB_W-1:0]                      job
);
	import pceo_pkg::*;

	localparam logic [1:0] CLS_START  = 2'b00;
	localparam logic [1:0] CLS_SINGLE = 2'b01;
	localparam logic [1:0] CLS_EDGE   = 2'b10;
	localparam logic [1:0] CLS_CLOSE  = 2'b11;

	logic                          in_poly_q;
	logic                          pend_q;
	logic [JOB_W-1:0]              pend_job_q;
	logic signed [COORD_BITS-1:0]  first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0]  circ_x_q, circ_y_q;
	logic [RADIUS_BITS-1:0]        circ_r_q;
	logic [1:0]                    cls;
	logic                          accept;
	logic                          new_push;
	logic [JOB_W-1:0]              new_job;

	assign cls      = {in_poly_q, last_vertex};
	assign in_ready = !q_stat.full && !pend_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		new_push = 1'b0;
		new_job  = '0;
		unique case (cls) inside
			CLS_SINGLE: begin
				new_push = 1'b1;
				new_job  = {1'b1, radius, center_y, center_x,
					vertex_y, vertex_x, vertex_y, vertex_x};
			end
			CLS_EDGE, CLS_CLOSE: begin
				new_push = 1'b1;
				new_job  = {1'b0, circ_r_q, circ_y_q, circ_x_q,
					vertex_y, vertex_x, prev_y_q, prev_x_q};
			end
			default: begin
				new_push = 1'b0;
			end
		endcase
	end

	// closing edge is held in pend_job_q and pushed once the queue is not full
	assign push = pend_q ? !q_stat.full : (accept && new_push);
	assign job  = pend_q ? pend_job_q : new_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (pend_q && !q_stat.full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				in_poly_q <= !last_vertex;
				pend_q    <= (cls == CLS_CLOSE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			if (!in_poly_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
				circ_x_q  <= center_x;
				circ_y_q  <= center_y;
				circ_r_q  <= radius;
			end
			if (cls == CLS_CLOSE) begin
				pend_job_q <= {1'b1, circ_r_q, circ_y_q, circ_x_q,
					first_y_q, first_x_q, vertex_y, vertex_x};
			end
		end
	end

endmodule

`default_nettype wire

### rtl/pceo_queue.sv
// ----------------------------------------------------------------------------
// pceo_queue
// short job queue between the vertex front end and the edge test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module pceo_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pceo_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic                  pop,
	output logic [WIDTH-1:0]           rd_data,
	output pceo_pkg::pceo_qstat_t      stat
);
	import pceo_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/pceo_back.sv
// ----------------------------------------------------------------------------
// pceo_back
// exact segment to circle distance test, one edge job per cycle while the output is not held, hit reduce
// ----------------------------------------------------------------------------
`default_nettype none

module pceo_back #(
	parameter int COORD_BITS = pceo_pkg::COORD_BITS_DEF,
	localparam int JOB_W = 6 * COORD_BITS + pceo_pkg::RADIUS_BITS + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pceo_pkg::pceo_qstat_t q_stat,
	input  wire logic [JOB_W-1:0]      job,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       hit
);
	import pceo_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int RB  = RADIUS_BITS;
	localparam int D   = CB + 1;
	localparam int P   = 2 * D;
	localparam int S   = 2 * D + 1;
	localparam int R2W = 2 * RB;
	localparam int MW  = ((S - 1) > R2W) ? (S - 1) : R2W;
	localparam int WW  = ((4 * D) > (R2W + 2 * D)) ? (4 * D + 1) : (R2W + 2 * D + 1);

	logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	logic [RB-1:0]        r_in;
	logic                 fin_in;
	logic                 en;

	// stage 1: differences
	logic                 v_s1, fin_s1;
	logic signed [D-1:0]  dx_s1, dy_s1, wx_s1, wy_s1, ex_s1, ey_s1;
	logic [RB-1:0]        r_s1;
	// stage 2: products
	logic                 v_s2, fin_s2;
	logic signed [P-1:0]  p_dxwx_s2, p_dywy_s2, p_dxdx_s2, p_dydy_s2;
	logic signed [P-1:0]  p_dxwy_s2, p_dywx_s2, p_wxwx_s2, p_wywy_s2;
	logic signed [P-1:0]  p_exex_s2, p_eyey_s2;
	logic [R2W-1:0]       r2_s2;
	// stage 3: dot, length, cross, endpoint distances
	logic                 v_s3, fin_s3;
	logic signed [S-1:0]  t_s3, len2_s3, da2_s3, db2_s3;
	logic [P-1:0]         c_s3;
	logic [R2W-1:0]       r2_s3;
	// stage 4: region select and partial products
	logic                 v_s4, fin_s4, perp_s4, pt_ok_s4;
	logic [P-1:0]         cc_hh_s4, cc_hl_s4, cc_ll_s4;
	logic [R2W+D-1:0]     rl_h_s4, rl_l_s4;
	// stage 5: wide products assembled
	logic                 v_s5, fin_s5, perp_s5, pt_ok_s5;
	logic [WW-1:0]        cc_s5, rl_s5;

	logic signed [S-1:0]  cr, cr_neg;
	logic                 le0, ge_len;
	logic                 da_ok, db_ok;
	logic [D-1:0]         ch, cl, lh, ll;
	logic                 edge_hit;
	logic                 acc_q;
	logic                 out_valid_q, out_hit_q;

	assign ax     = job[CB-1:0];
	assign ay     = job[2*CB-1:CB];
	assign bx     = job[3*CB-1:2*CB];
	assign by     = job[4*CB-1:3*CB];
	assign cx     = job[5*CB-1:4*CB];
	assign cy     = job[6*CB-1:5*CB];
	assign r_in   = job[6*CB+RB-1:6*CB];
	assign fin_in = job[JOB_W-1];

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;

	assign cr     = S'(p_dxwy_s2) - S'(p_dywx_s2);
	assign cr_neg = -cr;

	assign le0    = t_s3[S-1] || (t_s3 == '0);
	assign ge_len = (t_s3 >= len2_s3);
	assign da_ok  = (MW'(da2_s3[S-2:0]) <= MW'(r2_s3));
	assign db_ok  = (MW'(db2_s3[S-2:0]) <= MW'(r2_s3));
	assign ch     = c_s3[P-1:D];
	assign cl     = c_s3[D-1:0];
	assign lh     = len2_s3[P-1:D];
	assign ll     = len2_s3[D-1:0];

	assign edge_hit = perp_s5 ? (cc_s5 <= rl_s5) : pt_ok_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				if (v_s5) begin
					acc_q <= fin_s5 ? 1'b0 : (acc_q | edge_hit);
				end
			end
			if (en && v_s5 && fin_s5) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s1 <= fin_in;
			dx_s1  <= D'(bx) - D'(ax);
			dy_s1  <= D'(by) - D'(ay);
			wx_s1  <= D'(cx) - D'(ax);
			wy_s1  <= D'(cy) - D'(ay);
			ex_s1  <= D'(bx) - D'(cx);
			ey_s1  <= D'(by) - D'(cy);
			r_s1   <= r_in;

			fin_s2    <= fin_s1;
			p_dxwx_s2 <= dx_s1 * wx_s1;
			p_dywy_s2 <= dy_s1 * wy_s1;
			p_dxdx_s2 <= dx_s1 * dx_s1;
			p_dydy_s2 <= dy_s1 * dy_s1;
			p_dxwy_s2 <= dx_s1 * wy_s1;
			p_dywx_s2 <= dy_s1 * wx_s1;
			p_wxwx_s2 <= wx_s1 * wx_s1;
			p_wywy_s2 <= wy_s1 * wy_s1;
			p_exex_s2 <= ex_s1 * ex_s1;
			p_eyey_s2 <= ey_s1 * ey_s1;
			r2_s2     <= r_s1 * r_s1;

			fin_s3  <= fin_s2;
			t_s3    <= S'(p_dxwx_s2) + S'(p_dywy_s2);
			len2_s3 <= S'(p_dxdx_s2) + S'(p_dydy_s2);
			da2_s3  <= S'(p_wxwx_s2) + S'(p_wywy_s2);
			db2_s3  <= S'(p_exex_s2) + S'(p_eyey_s2);
			c_s3    <= cr[S-1] ? cr_neg[P-1:0] : cr[P-1:0];
			r2_s3   <= r2_s2;

			fin_s4   <= fin_s3;
			perp_s4  <= !le0 && !ge_len;
			pt_ok_s4 <= le0 ? da_ok : db_ok;
			cc_hh_s4 <= ch * ch;
			cc_hl_s4 <= ch * cl;
			cc_ll_s4 <= cl * cl;
			rl_h_s4  <= r2_s3 * lh;
			rl_l_s4  <= r2_s3 * ll;

			fin_s5   <= fin_s4;
			perp_s5  <= perp_s4;
			pt_ok_s5 <= pt_ok_s4;
			cc_s5    <= (WW'(cc_hh_s4) << (2 * D)) + (WW'(cc_hl_s4) << (D + 1))
				+ WW'(cc_ll_s4);
			rl_s5    <= (WW'(rl_h_s4) << D) + WW'(rl_l_s4);

			if (v_s5 && fin_s5) begin
				out_hit_q <= acc_q | edge_hit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;

endmodule

`default_nettype wire

### rtl/polygon_circle_edge_overlap_top.sv
// ----------------------------------------------------------------------------
// polygon_circle_edge_overlap_top
// circle versus polygon boundary overlap test over a stream of vertices
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one vertex per beat; the circle center and radius are
//   taken from the first vertex of a polygon, tlast marks its final vertex
//   m_axis gives one beat per polygon, on its last vertex: hit in bit 0
// throughput
//   one vertex per cycle while the job queue is not full; after the last
//   vertex of a polygon with two or more vertices, tready stays low
//   while the closing edge is queued
// result
//   m_axis_tvalid rises once the final job of a polygon, its closing
//   edge or single vertex point job, leaves the edge test pipeline,
//   which is fed from a four entry job queue
// reset
//   arst_n clears the queue, the pipeline valids and the output; the block
//   then waits for the first vertex of a new polygon
// stall
//   a result held on m_axis freezes the edge pipeline; vertices keep
//   entering until the job queue fills, then s_axis_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_circle_edge_overlap_top #(
	parameter int COORD_BITS = pceo_pkg::COORD_BITS_DEF,
	localparam int IN_W = ((4 * COORD_BITS + pceo_pkg::RADIUS_BITS + 7) / 8) * 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	// vertex_x, vertex_y, center_x, center_y, radius, zero fill
	input  wire logic [IN_W-1:0] s_axis_tdata,
	input  wire logic            s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	// hit, zero fill
	output logic [7:0]           m_axis_tdata
);
	import pceo_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int JOB_W = 6 * CB + RADIUS_BITS + 1;

	logic signed [CB-1:0]   vertex_x, vertex_y, center_x, center_y;
	logic [RADIUS_BITS-1:0] radius;
	pceo_qstat_t            q_stat;
	logic                   q_push, q_pop;
	logic [JOB_W-1:0]       q_wr_job, q_rd_job;
	logic                   hit;

	assign vertex_x = s_axis_tdata[CB-1:0];
	assign vertex_y = s_axis_tdata[2*CB-1:CB];
	assign center_x = s_axis_tdata[3*CB-1:2*CB];
	assign center_y = s_axis_tdata[4*CB-1:3*CB];
	assign radius   = s_axis_tdata[4*CB+RADIUS_BITS-1:4*CB];

	pceo_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.last_vertex (s_axis_tlast),
		.q_stat      (q_stat),
		.push        (q_push),
		.job         (q_wr_job)
	);

	pceo_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_job),
		.pop     (q_pop),
		.rd_data (q_rd_job),
		.stat    (q_stat)
	);

	pceo_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.job       (q_rd_job),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.hit       (hit)
	);

	assign m_axis_tdata = {7'b0, hit};

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("edge job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("edge job popped from an empty queue");

	a_qstat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");
`endif

endmodule

`default_nettype wire
